>>> sv/gaussian_blur_sobel_edge_macros.svh
// Assertion macros used by the edge detector controller, gbse_ctrl.
// Each macro expects aclk and aresetn in scope at the point of use.
`ifndef GAUSSIAN_BLUR_SOBEL_EDGE_MACROS_SVH
`define GAUSSIAN_BLUR_SOBEL_EDGE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GBSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gbse check failed");

// Next-cycle implication, disabled while reset is held.
`define GBSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gbse check failed");

`endif

>>> sv/gbse_pkg.sv
// Shared constants, types and helper functions for the blur and edge block.
// Used by every module of the block except gbse_ram; depends on nothing.
package gbse_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int RING_ROWS  = 8;
    localparam int ROW_SEL_W  = $clog2(RING_ROWS);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ADDR_W     = ROW_SEL_W + COL_W;
    localparam int LINE_DEPTH = RING_ROWS * MAX_WIDTH;

    localparam int PIX_W      = 8;
    localparam int CW_W       = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int TOTAL_W    = 11;
    localparam int ACC_W      = 19;
    localparam int GRAD_W     = 12;
    localparam int LAG_W      = 12;
    localparam int RATIO_W    = 24;
    localparam int TAP_COUNT  = 25;
    localparam int TAP_CNT_W  = 5;
    localparam int MIN_DIM    = 6;

    localparam logic [RATIO_W-1:0] RATIO_HALF = 24'd10175896;
    localparam logic [RATIO_W-1:0] RATIO_TWO  = 24'd2270549;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd2;

    typedef struct packed {
        logic kern;
        logic take;
        logic edge_init;
        logic cell_init;
        logic tap;
        logic div;
        logic sum;
        logic mag;
    } gbse_cmd_t;

    typedef struct packed {
        logic cfg_hit;
        logic emit;
        logic edge_border;
        logic cell_inside;
        logic taps_done;
        logic div_done;
        logic last_cell;
    } gbse_status_t;

    // Q0.24 scaling of a kernel tap, truncating
    function automatic logic [CW_W-1:0] scale_tap(input logic [CW_W-1:0] v,
                                                  input logic [RATIO_W-1:0] ratio);
        logic [31:0] p;
        p = 32'(v) * 32'(ratio);
        return p[31:24];
    endfunction

    // distance of a 5-wide window position from its center
    function automatic logic [1:0] tap_dist(input logic [2:0] d);
        logic [1:0] r;
        case (d)
            3'd0: r = 2'd2;
            3'd1: r = 2'd1;
            3'd2: r = 2'd0;
            3'd3: r = 2'd1;
            3'd4: r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/gbse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/gbse_datapath.sv
// Datapath: configuration, kernel derivation, raster positions, line store,
// blur MAC and divider, Sobel accumulation. Depends on gbse_pkg, gbse_ram.
module gbse_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [gbse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbse_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [7:0]                          s_axis_tdata, // [7:0] pixel
    input  logic                                s_axis_tuser, // [0] op
    input  gbse_pkg::gbse_cmd_t                 cmd,
    output gbse_pkg::gbse_status_t              st,
    output logic [7:0]                          m_axis_tdata, // [7:0] edge_value
    output logic                                m_axis_tlast
);

    logic [gbse_pkg::CW_W-1:0]     cw_reg;
    logic [gbse_pkg::WIDTH_W-1:0]  width_reg;
    logic [gbse_pkg::HEIGHT_W-1:0] height_reg;
    logic                          cfg_hit;
    logic [gbse_pkg::WIDTH_W-1:0]  w;
    logic [gbse_pkg::HEIGHT_W-1:0] h;

    assign cfg_hit = cfg_we && (cfg_index == gbse_pkg::REG_CENTER_WEIGHT ||
                                cfg_index == gbse_pkg::REG_IMAGE_WIDTH ||
                                cfg_index == gbse_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg     <= 8'd16;
            width_reg  <= 11'd640;
            height_reg <= 12'd480;
        end else if (cfg_hit) begin
            case (cfg_index)
                gbse_pkg::REG_CENTER_WEIGHT: cw_reg     <= cfg_wdata[gbse_pkg::CW_W-1:0];
                gbse_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_wdata[gbse_pkg::WIDTH_W-1:0];
                gbse_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg < gbse_pkg::WIDTH_W'(gbse_pkg::MIN_DIM)) begin
            w = gbse_pkg::WIDTH_W'(gbse_pkg::MIN_DIM);
        end else if (width_reg > gbse_pkg::WIDTH_W'(gbse_pkg::MAX_WIDTH)) begin
            w = gbse_pkg::WIDTH_W'(gbse_pkg::MAX_WIDTH);
        end else begin
            w = width_reg;
        end
        h = (height_reg < gbse_pkg::HEIGHT_W'(gbse_pkg::MIN_DIM)) ?
            gbse_pkg::HEIGHT_W'(gbse_pkg::MIN_DIM) : height_reg;
    end

    // kernel: three registered stages, refreshed while the controller holds kern
    logic [gbse_pkg::CW_W-1:0]    v0;
    logic [gbse_pkg::CW_W-1:0]    kv_reg  [3];
    logic [gbse_pkg::CW_W-1:0]    tap_reg [3][3];
    logic [gbse_pkg::TOTAL_W-1:0] total_reg;
    logic [gbse_pkg::TOTAL_W-1:0] total_sum;

    assign v0 = (cw_reg == '0) ? gbse_pkg::CW_W'(1) : cw_reg;

    always_comb begin
        total_sum = '0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                total_sum = total_sum + (gbse_pkg::TOTAL_W'(tap_reg[a][b])
                            << ((a != 0 ? 1 : 0) + (b != 0 ? 1 : 0)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.kern) begin
            kv_reg[0] <= v0;
            kv_reg[1] <= gbse_pkg::scale_tap(v0, gbse_pkg::RATIO_HALF);
            kv_reg[2] <= gbse_pkg::scale_tap(v0, gbse_pkg::RATIO_TWO);
            for (int a = 0; a < 3; a++) begin
                tap_reg[a][0] <= kv_reg[a];
                tap_reg[a][1] <= gbse_pkg::scale_tap(kv_reg[a], gbse_pkg::RATIO_HALF);
                tap_reg[a][2] <= gbse_pkg::scale_tap(kv_reg[a], gbse_pkg::RATIO_TWO);
            end
            total_reg <= total_sum;
        end
    end

    // raster positions
    logic [gbse_pkg::HEIGHT_W-1:0] in_row_reg, out_row_reg, ir, orr, orw, or_adv, ir_adv;
    logic [gbse_pkg::WIDTH_W-1:0]  in_col_reg, out_col_reg, ic, oc, ocw, oc_adv, ic_adv;
    logic [gbse_pkg::LAG_W-1:0]    lag_reg, lag_e, lag_target, lag_next;
    logic                          pos_bad, frame_done, pending, emit, op;

    assign op = s_axis_tuser;
    assign lag_target = gbse_pkg::LAG_W'(w) + gbse_pkg::LAG_W'({w, 1'b0}) +
                        gbse_pkg::LAG_W'(3);

    always_comb begin
        pos_bad = (in_row_reg >= h) || (in_col_reg >= w) ||
                  (out_row_reg >= h) || (out_col_reg >= w);
        ir  = pos_bad ? '0 : in_row_reg;
        ic  = pos_bad ? '0 : in_col_reg;
        orr = pos_bad ? '0 : out_row_reg;
        oc  = pos_bad ? '0 : out_col_reg;
        frame_done = (ir == '0) && (ic == '0);
        pending    = (orr != '0) || (oc != '0);
        lag_e      = frame_done ? '0 : lag_reg;
        if (op) begin
            orw  = orr;
            ocw  = oc;
            emit = frame_done && pending;
        end else begin
            orw  = (frame_done && pending) ? '0 : orr;
            ocw  = (frame_done && pending) ? '0 : oc;
            emit = (lag_e == lag_target);
        end
        lag_next = lag_e + gbse_pkg::LAG_W'(1) - gbse_pkg::LAG_W'(emit);
        // advance the result position
        if (gbse_pkg::WIDTH_W'(ocw + 1'b1) >= w) begin
            oc_adv = '0;
            or_adv = (13'(orw) + 13'd1 >= 13'(h)) ? '0 : orw + 1'b1;
        end else begin
            oc_adv = ocw + 1'b1;
            or_adv = orw;
        end
        // advance the input position
        if (ic + 1'b1 >= w) begin
            ic_adv = '0;
            ir_adv = (13'(ir) + 13'd1 >= 13'(h)) ? '0 : ir + 1'b1;
        end else begin
            ic_adv = ic + 1'b1;
            ir_adv = ir;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            lag_reg     <= '0;
        end else if (cmd.take) begin
            out_row_reg <= emit ? or_adv : orw;
            out_col_reg <= emit ? oc_adv : ocw;
            if (op) begin
                in_row_reg <= ir;
                in_col_reg <= ic;
            end else begin
                in_row_reg <= ir_adv;
                in_col_reg <= ic_adv;
                lag_reg    <= lag_next;
            end
        end
    end

    // result position captured at emission
    logic [gbse_pkg::HEIGHT_W-1:0] oy_reg;
    logic [gbse_pkg::WIDTH_W-1:0]  ox_reg;
    logic                          last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take && emit) begin
            oy_reg   <= orw;
            ox_reg   <= ocw;
            last_reg <= (13'(orw) + 13'd1 == 13'(h)) && (12'(ocw) + 12'd1 == 12'(w));
        end
    end

    // line store
    logic [gbse_pkg::ADDR_W-1:0]  waddr, raddr;
    logic [gbse_pkg::PIX_W-1:0]   rdata;

    assign waddr = {ir[gbse_pkg::ROW_SEL_W-1:0], ic[gbse_pkg::COL_W-1:0]};

    gbse_ram #(
        .WIDTH (gbse_pkg::PIX_W),
        .DEPTH (gbse_pkg::LINE_DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (cmd.take && !op),
        .waddr (waddr),
        .wdata (s_axis_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // window cell and tap walk
    logic [1:0]                     r_reg, c_reg;
    logic [2:0]                     di_reg, dj_reg, k_reg;
    logic [gbse_pkg::TAP_CNT_W-1:0] n_reg;
    logic                           rv_reg, issue;
    logic [gbse_pkg::CW_W-1:0]      tw_reg;
    logic [gbse_pkg::ACC_W-1:0]     acc_reg, shifted;
    logic [7:0]                     q_reg;
    logic [gbse_pkg::HEIGHT_W-1:0]  y, row_pos;
    logic [gbse_pkg::WIDTH_W-1:0]   x, col_pos;

    assign y       = oy_reg - 12'd1 + 12'(r_reg);
    assign x       = ox_reg - 11'd1 + 11'(c_reg);
    assign row_pos = y + 12'(di_reg) - 12'd2;
    assign col_pos = x + 11'(dj_reg) - 11'd2;
    assign raddr   = {row_pos[gbse_pkg::ROW_SEL_W-1:0], col_pos[gbse_pkg::COL_W-1:0]};
    assign issue   = cmd.tap && (n_reg != gbse_pkg::TAP_CNT_W'(gbse_pkg::TAP_COUNT));
    assign shifted = gbse_pkg::ACC_W'(total_reg) << k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg <= 1'b0;
        end else if (cmd.cell_init) begin
            n_reg   <= '0;
            di_reg  <= '0;
            dj_reg  <= '0;
            acc_reg <= '0;
            q_reg   <= '0;
            k_reg   <= 3'd7;
            rv_reg  <= 1'b0;
        end else if (cmd.tap) begin
            if (issue) begin
                n_reg <= n_reg + 1'b1;
                if (dj_reg == 3'd4) begin
                    dj_reg <= '0;
                    di_reg <= di_reg + 1'b1;
                end else begin
                    dj_reg <= dj_reg + 1'b1;
                end
            end
            rv_reg <= issue;
            tw_reg <= tap_reg[gbse_pkg::tap_dist(di_reg)][gbse_pkg::tap_dist(dj_reg)];
            if (rv_reg) begin
                acc_reg <= acc_reg + gbse_pkg::ACC_W'(16'(tw_reg) * 16'(rdata));
            end
        end else if (cmd.div) begin
            if (acc_reg >= shifted) begin
                acc_reg      <= acc_reg - shifted;
                q_reg[k_reg] <= 1'b1;
            end
            k_reg <= k_reg - 1'b1;
        end
    end

    // Sobel accumulation and magnitude
    logic signed [gbse_pkg::GRAD_W-1:0] gx_reg, gy_reg, q1, q2, tx, ty;
    logic [gbse_pkg::GRAD_W-1:0]        ax, ay, mag;

    assign q1 = signed'(gbse_pkg::GRAD_W'(q_reg));
    assign q2 = signed'(gbse_pkg::GRAD_W'({q_reg, 1'b0}));

    always_comb begin
        case (c_reg)
            2'd0:    tx = (r_reg == 2'd1) ? q2 : q1;
            2'd2:    tx = (r_reg == 2'd1) ? -q2 : -q1;
            default: tx = '0;
        endcase
        case (r_reg)
            2'd0:    ty = (c_reg == 2'd1) ? q2 : q1;
            2'd2:    ty = (c_reg == 2'd1) ? -q2 : -q1;
            default: ty = '0;
        endcase
        ax  = (gx_reg < 0) ? unsigned'(-gx_reg) : unsigned'(gx_reg);
        ay  = (gy_reg < 0) ? unsigned'(-gy_reg) : unsigned'(gy_reg);
        mag = ax + ay;
    end

    always_ff @(posedge aclk) begin
        if (cmd.edge_init) begin
            gx_reg <= '0;
            gy_reg <= '0;
            r_reg  <= '0;
            c_reg  <= '0;
        end else if (cmd.sum) begin
            gx_reg <= gx_reg + tx;
            gy_reg <= gy_reg + ty;
            if (c_reg == 2'd2) begin
                c_reg <= '0;
                r_reg <= r_reg + 1'b1;
            end else begin
                c_reg <= c_reg + 1'b1;
            end
        end
        if (cmd.mag) begin
            m_axis_tdata <= (mag > 12'd255) ? 8'd255 : mag[7:0];
        end
    end

    assign m_axis_tlast = last_reg;

    always_comb begin
        st.cfg_hit     = cfg_hit;
        st.emit        = emit;
        st.edge_border = (oy_reg == '0) || (13'(oy_reg) + 13'd1 >= 13'(h)) ||
                         (ox_reg == '0) || (12'(ox_reg) + 12'd1 >= 12'(w));
        st.cell_inside = (y >= 12'd2) && (13'(y) + 13'd3 <= 13'(h)) &&
                         (x >= 11'd2) && (12'(x) + 12'd3 <= 12'(w));
        st.taps_done   = rv_reg && (n_reg == gbse_pkg::TAP_CNT_W'(gbse_pkg::TAP_COUNT));
        st.div_done    = (k_reg == 3'd0);
        st.last_cell   = (r_reg == 2'd2) && (c_reg == 2'd2);
    end

endmodule

>>> sv/gbse_ctrl.sv
// Controller state machine sequencing the datapath for one transaction at a time.
// Depends on gbse_pkg and gaussian_blur_sobel_edge_macros.svh.
`include "gaussian_blur_sobel_edge_macros.svh"
module gbse_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  gbse_pkg::gbse_status_t st,
    output gbse_pkg::gbse_cmd_t    cmd
);

    localparam logic [3:0] S_KERN  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_CELL  = 4'd3;
    localparam logic [3:0] S_TAPS  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_MAG   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] kcnt_reg, kcnt_next;
    logic       s_fire;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        state_next = state_reg;
        kcnt_next  = kcnt_reg;
        cmd        = '0;
        case (state_reg)
            S_KERN: begin
                cmd.kern  = 1'b1;
                kcnt_next = kcnt_reg + 1'b1;
                if (kcnt_reg == 2'd2) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.take = s_axis_tvalid;
                if (s_axis_tvalid && st.emit) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd.edge_init = 1'b1;
                state_next    = st.edge_border ? S_MAG : S_CELL;
            end
            S_CELL: begin
                cmd.cell_init = 1'b1;
                state_next    = st.cell_inside ? S_TAPS : S_SUM;
            end
            S_TAPS: begin
                cmd.tap = 1'b1;
                if (st.taps_done) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div = 1'b1;
                if (st.div_done) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = st.last_cell ? S_MAG : S_CELL;
            end
            S_MAG: begin
                cmd.mag    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_KERN;
        endcase
        // a register write rebuilds the kernel and drops any frame in progress
        if (st.cfg_hit) begin
            state_next = S_KERN;
            kcnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_KERN;
            kcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            kcnt_reg  <= kcnt_next;
        end
    end

    `GBSE_ASSERT_NOW(a_sides_exclusive, s_axis_tready, !m_axis_tvalid)
    `GBSE_ASSERT_NEXT(a_cfg_blocks_input, st.cfg_hit, !s_axis_tready)
    `GBSE_ASSERT_NEXT(a_no_result_back_idle, s_fire && !st.emit && !st.cfg_hit, s_axis_tready)

endmodule

>>> sv/gaussian_blur_sobel_edge.sv
// Streaming 5x5 Gaussian blur followed by a 3x3 Sobel L1 edge magnitude.
// Input channel s_axis_*: tuser = op (0 pixel, 1 drain tick), tdata = pixel.
// Result channel m_axis_*: tdata = edge magnitude, tlast = last result of a frame.
// Configuration: cfg_we / cfg_index / cfg_wdata; 0 center weight, 1 width,
//   2 height. Any write to one of these rebuilds the kernel and restarts the frame.
// One transaction is handled at a time. Results trail the input by 3*width+3
//   transactions; drain ticks after a frame's last pixel flush the tail.
// An interior result computes up to 9 blur values, each from 25 line-store
//   reads through the single read port plus an 8-step divider; a border
//   result computes none and is zero.
// The result stays on m_axis_tdata until taken; while the receiver stalls,
//   s_axis_tready stays low.
// Reset (aresetn, synchronous, active low) loads center weight 16, 640x480,
//   clears all positions and rebuilds the kernel before the first transaction.
// Line store: 8 rows of 1024 pixels in one RAM; stale entries are never read.
module gaussian_blur_sobel_edge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [gbse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbse_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata, // [7:0] pixel
    input  logic                                s_axis_tuser, // [0] op
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata, // [7:0] edge_value
    output logic                                m_axis_tlast
);

    gbse_pkg::gbse_cmd_t    cmd;
    gbse_pkg::gbse_status_t st;

    gbse_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .st            (st),
        .cmd           (cmd)
    );

    gbse_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .cmd          (cmd),
        .st           (st),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule
